FILE: rtl/vccp_pkg.sv
`default_nettype none

package vccp_pkg;

  localparam int REG_W       = 13;
  localparam int CFG_AW      = 2;
  localparam int CNT_W       = 25;
  localparam int MAX_DIM_DEF = 4096;
  localparam int QDEPTH_DEF  = 8;

  localparam logic [7:0]       PAD_LUMA   = 8'h10;
  localparam logic [7:0]       PAD_CHROMA = 8'h80;
  localparam logic [CNT_W-1:0] CNT_MAX    = {CNT_W{1'b1}};

  localparam logic [REG_W-1:0] RST_IN_WIDTH   = 13'd1920;
  localparam logic [REG_W-1:0] RST_IN_HEIGHT  = 13'd1080;
  localparam logic [REG_W-1:0] RST_OUT_WIDTH  = 13'd1920;
  localparam logic [REG_W-1:0] RST_OUT_HEIGHT = 13'd1080;

  typedef enum logic [CFG_AW-1:0] {
    REG_IN_WIDTH   = 2'd0,
    REG_IN_HEIGHT  = 2'd1,
    REG_OUT_WIDTH  = 2'd2,
    REG_OUT_HEIGHT = 2'd3
  } cfg_reg_t;

  // One bit per result an item can cause, lowest bit emitted first.
  typedef logic [4:0] res_mask_t;
  localparam res_mask_t RES_TOP    = 5'b00001;
  localparam res_mask_t RES_LEFT   = 5'b00010;
  localparam res_mask_t RES_PIX    = 5'b00100;
  localparam res_mask_t RES_RIGHT  = 5'b01000;
  localparam res_mask_t RES_BOTTOM = 5'b10000;

  typedef struct packed {
    logic [7:0] luma;
    logic [7:0] chroma;
    res_mask_t  mask;
    logic       last_pix;
  } item_t;

  typedef struct packed {
    logic [CNT_W-1:0] top;
    logic [CNT_W-1:0] left;
    logic [CNT_W-1:0] right;
    logic [CNT_W-1:0] bottom;
  } pad_t;

endpackage

`default_nettype wire

FILE: rtl/vccp_front.sv
`default_nettype none

module vccp_front #(
  parameter int MAX_DIM = vccp_pkg::MAX_DIM_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_write,
  input  wire logic [vccp_pkg::CFG_AW-1:0]   cfg_addr,
  input  wire logic [vccp_pkg::REG_W-1:0]    cfg_data,
  input  wire logic                          take,
  input  wire logic [7:0]                    luma,
  input  wire logic [7:0]                    chroma,
  input  wire logic                          frame_start,
  output logic [1:0]                         inflight,
  output logic                               enq_valid,
  output vccp_pkg::item_t                    enq_item,
  output vccp_pkg::pad_t                     pad
);
  import vccp_pkg::*;

  localparam int SZ_W   = $clog2(MAX_DIM + 1);
  localparam int POS_W  = $clog2(MAX_DIM);
  localparam int CW     = (SZ_W > REG_W) ? SZ_W : REG_W;
  localparam int CMP_W  = SZ_W + 1;
  localparam int PROD_W = 2 * SZ_W;
  localparam int SAT_W  = (PROD_W > CNT_W) ? PROD_W : CNT_W;

  typedef struct packed {
    logic [SZ_W-1:0] skip;
    logic [SZ_W-1:0] pre;
    logic [SZ_W-1:0] post;
    logic [SZ_W-1:0] keep;
  } axis_t;

  function automatic logic [SZ_W-1:0] eff(input logic [REG_W-1:0] v);
    logic [CW-1:0] x;
    x = CW'(v);
    if (x == '0) eff = SZ_W'(1);
    else if (x > CW'(MAX_DIM)) eff = SZ_W'(MAX_DIM);
    else eff = SZ_W'(x);
  endfunction

  function automatic axis_t axis(input logic [SZ_W-1:0] src, input logic [SZ_W-1:0] dst);
    axis_t a;
    logic [SZ_W-1:0] d;
    if (src > dst) begin
      d = src - dst;
      a.skip = d >> 1;
      a.pre  = '0;
      a.post = '0;
      a.keep = dst;
    end else begin
      d = dst - src;
      a.skip = '0;
      a.pre  = d >> 1;
      a.post = d - (d >> 1);
      a.keep = src;
    end
    axis = a;
  endfunction

  function automatic logic [CNT_W-1:0] sat(input logic [PROD_W-1:0] p);
    logic [SAT_W-1:0] x;
    x = SAT_W'(p);
    if (x > SAT_W'(CNT_MAX)) sat = CNT_MAX;
    else sat = CNT_W'(x);
  endfunction

  // Configuration registers.
  logic [REG_W-1:0] in_width, in_height, out_width, out_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_width   <= RST_IN_WIDTH;
      in_height  <= RST_IN_HEIGHT;
      out_width  <= RST_OUT_WIDTH;
      out_height <= RST_OUT_HEIGHT;
    end else if (cfg_write) begin
      case (cfg_addr)
        REG_IN_WIDTH:   in_width   <= cfg_data;
        REG_IN_HEIGHT:  in_height  <= cfg_data;
        REG_OUT_WIDTH:  out_width  <= cfg_data;
        REG_OUT_HEIGHT: out_height <= cfg_data;
        default:        in_width   <= in_width;
      endcase
    end
  end

  // Window geometry, recomputed every cycle over three register stages.
  // It is settled before any item accepted after a write reaches classification.
  logic [SZ_W-1:0]   iw1, ih1, ow1, oh1;
  axis_t             ax_h, ax_v;
  logic [PROD_W-1:0] top_prod, bot_prod;
  logic [CMP_W-1:0]  x_end, y_end;

  always_ff @(posedge clk) begin
    iw1      <= eff(in_width);
    ih1      <= eff(in_height);
    ow1      <= eff(out_width);
    oh1      <= eff(out_height);
    ax_h     <= axis(iw1, ow1);
    ax_v     <= axis(ih1, oh1);
    top_prod <= PROD_W'(ax_v.pre) * PROD_W'(ow1);
    bot_prod <= PROD_W'(ax_v.post) * PROD_W'(ow1);
    x_end    <= CMP_W'(ax_h.skip) + CMP_W'(ax_h.keep);
    y_end    <= CMP_W'(ax_v.skip) + CMP_W'(ax_v.keep);
  end

  always_comb begin
    pad.top    = sat(top_prod);
    pad.bottom = sat(bot_prod);
    pad.left   = CNT_W'(ax_h.pre);
    pad.right  = CNT_W'(ax_h.post);
  end

  // Source position, advanced at every accepted pixel while the frame is live.
  logic [POS_W-1:0] col, row, col_next, row_next, c0, r0;
  logic             frame_done, frame_done_next, live;
  logic [SZ_W-1:0]  iw_c, ih_c;
  logic [CMP_W-1:0] col_inc, row_inc;

  always_comb begin
    iw_c = eff(in_width);
    ih_c = eff(in_height);
    c0   = frame_start ? '0 : col;
    r0   = frame_start ? '0 : row;
    live = frame_start || !frame_done;
    col_inc = CMP_W'(c0) + CMP_W'(1);
    row_inc = CMP_W'(r0) + CMP_W'(1);
    col_next = col_inc[POS_W-1:0];
    row_next = r0;
    frame_done_next = 1'b0;
    if (col_inc >= CMP_W'(iw_c)) begin
      col_next = '0;
      if (row_inc >= CMP_W'(ih_c)) begin
        row_next = '0;
        frame_done_next = 1'b1;
      end else begin
        row_next = row_inc[POS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col        <= '0;
      row        <= '0;
      frame_done <= 1'b0;
    end else if (take && live) begin
      col        <= col_next;
      row        <= row_next;
      frame_done <= frame_done_next;
    end
  end

  // Three-stage item pipeline in front of the classifier.
  logic             s1_v, s2_v, s3_v;
  logic [7:0]       s1_l, s2_l, s3_l, s1_c, s2_c, s3_c;
  logic [POS_W-1:0] s1_x, s2_x, s3_x, s1_y, s2_y, s3_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
    end else begin
      s1_v <= take && live;
      s2_v <= s1_v;
      s3_v <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    s1_l <= luma;
    s1_c <= chroma;
    s1_x <= c0;
    s1_y <= r0;
    s2_l <= s1_l;
    s2_c <= s1_c;
    s2_x <= s1_x;
    s2_y <= s1_y;
    s3_l <= s2_l;
    s3_c <= s2_c;
    s3_x <= s2_x;
    s3_y <= s2_y;
  end

  assign inflight = 2'(s1_v) + 2'(s2_v) + 2'(s3_v);

  // Classification: which results this pixel causes.
  logic [CMP_W-1:0] cx, cy;
  logic             in_row, in_col, col_last, row_last;
  res_mask_t        mask;

  always_comb begin
    cx = CMP_W'(s3_x);
    cy = CMP_W'(s3_y);
    in_row   = (cy >= CMP_W'(ax_v.skip)) && (cy < y_end);
    in_col   = in_row && (cx >= CMP_W'(ax_h.skip)) && (cx < x_end);
    col_last = in_col && (cx + CMP_W'(1) == x_end);
    row_last = col_last && (cy + CMP_W'(1) == y_end);
    mask = '0;
    if (cx == '0 && cy == '0 && ax_v.pre != '0) mask = mask | RES_TOP;
    if (in_row && cx == '0 && ax_h.pre != '0) mask = mask | RES_LEFT;
    if (in_col) mask = mask | RES_PIX;
    if (col_last && ax_h.post != '0) mask = mask | RES_RIGHT;
    if (row_last && ax_v.post != '0) mask = mask | RES_BOTTOM;
    enq_valid         = s3_v && (mask != '0);
    enq_item.luma     = s3_l;
    enq_item.chroma   = s3_c;
    enq_item.mask     = mask;
    enq_item.last_pix = row_last;
  end

endmodule

`default_nettype wire

FILE: rtl/vccp_queue.sv
`default_nettype none

module vccp_queue #(
  parameter int DEPTH = vccp_pkg::QDEPTH_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      wr_en,
  input  wire vccp_pkg::item_t           wr_item,
  input  wire logic                      rd_en,
  output vccp_pkg::item_t                rd_item,
  output logic [$clog2(DEPTH+1)-1:0]     count
);
  import vccp_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int QCW   = $clog2(DEPTH + 1);

  item_t             store [DEPTH];
  logic [PTR_W-1:0]  wr_ptr, rd_ptr;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({wr_en, rd_en})
        2'b10:   count <= count + QCW'(1);
        2'b01:   count <= count - QCW'(1);
        default: count <= count;
      endcase
    end
  end

  assign rd_item = store[rd_ptr];

endmodule

`default_nettype wire

FILE: rtl/vccp_back.sv
`default_nettype none

module vccp_back (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          head_valid,
  input  wire vccp_pkg::item_t               head,
  input  wire vccp_pkg::pad_t                pad,
  output logic                               deq,
  input  wire logic                          pop,
  output logic                               empty,
  output logic [7:0]                         out_luma,
  output logic [7:0]                         out_chroma,
  output logic [vccp_pkg::CNT_W-1:0]         repeat_count,
  output logic                               group_last,
  output logic                               frame_last
);
  import vccp_pkg::*;

  // done marks the results of the head item already sent.
  res_mask_t        done, remaining, sel;
  logic             last_one, load, out_valid;
  logic [7:0]       res_l, res_c;
  logic [CNT_W-1:0] res_n;

  always_comb begin
    remaining = head.mask & ~done;
    sel       = remaining & (~remaining + 5'd1);
    last_one  = (remaining == sel);
    load      = head_valid && (!out_valid || pop);
    deq       = load && last_one;
    case (sel)
      RES_TOP: begin
        res_l = PAD_LUMA;
        res_c = PAD_CHROMA;
        res_n = pad.top;
      end
      RES_LEFT: begin
        res_l = PAD_LUMA;
        res_c = PAD_CHROMA;
        res_n = pad.left;
      end
      RES_PIX: begin
        res_l = head.luma;
        res_c = head.chroma;
        res_n = CNT_W'(1);
      end
      RES_RIGHT: begin
        res_l = PAD_LUMA;
        res_c = PAD_CHROMA;
        res_n = pad.right;
      end
      RES_BOTTOM: begin
        res_l = PAD_LUMA;
        res_c = PAD_CHROMA;
        res_n = pad.bottom;
      end
      default: begin
        res_l = PAD_LUMA;
        res_c = PAD_CHROMA;
        res_n = CNT_W'(1);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      done      <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        done      <= last_one ? '0 : (done | sel);
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_luma     <= res_l;
      out_chroma   <= res_c;
      repeat_count <= res_n;
      group_last   <= last_one;
      frame_last   <= last_one && head.last_pix;
    end
  end

  assign empty = !out_valid;

endmodule

`default_nettype wire

FILE: rtl/video_center_crop_pad_unit.sv
// Path: a pixel accepted at the input passes the three front stages, the queue and
// the output register before its first result shows on the result ports.
// Throughput: one pixel per cycle in unless full; one result per cycle out while pop
// is high; while a pixel's k results drain, the queue absorbs the input.
// Reset (synchronous, active high) restores 1920x1080 in both sizes and clears
// position, queue and output; derived geometry settles through its register stages.
`default_nettype none

module video_center_crop_pad_unit #(
  parameter int MAX_DIM     = vccp_pkg::MAX_DIM_DEF,
  parameter int QUEUE_DEPTH = vccp_pkg::QDEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_write,
  input  wire logic [vccp_pkg::CFG_AW-1:0]   cfg_addr,
  input  wire logic [vccp_pkg::REG_W-1:0]    cfg_data,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic [7:0]                    luma,
  input  wire logic [7:0]                    chroma,
  input  wire logic                          frame_start,
  output logic                               empty,
  input  wire logic                          pop,
  output logic [7:0]                         out_luma,
  output logic [7:0]                         out_chroma,
  output logic [vccp_pkg::CNT_W-1:0]         repeat_count,
  output logic                               group_last,
  output logic                               frame_last
);
  import vccp_pkg::*;

  localparam int QCW = $clog2(QUEUE_DEPTH + 1);

  logic [1:0]     inflight;
  logic           enq_valid, deq, take;
  item_t          enq_item, head;
  pad_t           pad;
  logic [QCW-1:0] q_count;

  // Pixels still in the front stages hold a queue slot in advance, so the
  // front never has to stall.
  assign full = (QCW'(q_count) + QCW'(inflight)) >= QCW'(QUEUE_DEPTH);
  assign take = push && !full;

  vccp_front #(.MAX_DIM(MAX_DIM)) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_addr    (cfg_addr),
    .cfg_data    (cfg_data),
    .take        (take),
    .luma        (luma),
    .chroma      (chroma),
    .frame_start (frame_start),
    .inflight    (inflight),
    .enq_valid   (enq_valid),
    .enq_item    (enq_item),
    .pad         (pad)
  );

  vccp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (enq_valid),
    .wr_item (enq_item),
    .rd_en   (deq),
    .rd_item (head),
    .count   (q_count)
  );

  vccp_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (q_count != '0),
    .head         (head),
    .pad          (pad),
    .deq          (deq),
    .pop          (pop),
    .empty        (empty),
    .out_luma     (out_luma),
    .out_chroma   (out_chroma),
    .repeat_count (repeat_count),
    .group_last   (group_last),
    .frame_last   (frame_last)
  );

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= QCW'(QUEUE_DEPTH))
    else $error("queue holds more entries than its depth");

  a_no_enq_when_full: assert property (@(posedge clk) disable iff (rst)
    (q_count == QCW'(QUEUE_DEPTH)) |-> !enq_valid)
    else $error("front wrote into a full queue");

  a_frame_last_ends_group: assert property (@(posedge clk) disable iff (rst)
    (!empty && frame_last) |-> group_last)
    else $error("frame end flagged on a result that is not the last of its pixel");

  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (repeat_count != '0))
    else $error("result with a zero repeat count");

endmodule

`default_nettype wire

FILE: bench/video_center_crop_pad_unit_tb.sv
module video_center_crop_pad_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import vccp_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int DIM_CAP      = MAX_DIM_DEF;

  typedef struct packed {
    logic [7:0] luma;
    logic [7:0] chroma;
    logic       frame_start;
  } pixel_t;

  typedef struct packed {
    logic [7:0]       luma;
    logic [7:0]       chroma;
    logic [CNT_W-1:0] count;
    logic             group_end;
    logic             frame_end;
  } run_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_write = 1'b0;
  cfg_reg_t         cfg_addr = REG_IN_WIDTH;
  logic [REG_W-1:0] cfg_data = '0;
  logic             push = 1'b0;
  logic [7:0]       luma = '0;
  logic [7:0]       chroma = '0;
  logic             frame_start = 1'b0;
  logic             pop = 1'b0;
  logic             full;
  logic             empty;
  logic [7:0]       out_luma;
  logic [7:0]       out_chroma;
  logic [CNT_W-1:0] repeat_count;
  logic             group_last;
  logic             frame_last;

  pixel_t pending_pixels[$];
  run_t   expected_runs[$];

  // Shadow copy of the size registers and of the source position.
  logic [REG_W-1:0] in_w_reg = RST_IN_WIDTH;
  logic [REG_W-1:0] in_h_reg = RST_IN_HEIGHT;
  logic [REG_W-1:0] out_w_reg = RST_OUT_WIDTH;
  logic [REG_W-1:0] out_h_reg = RST_OUT_HEIGHT;
  int unsigned      src_col = 0;
  int unsigned      src_row = 0;
  bit               src_done = 1'b0;

  bit calm = 1'b0;
  int errors = 0;
  int cycles = 0;
  int items_sent = 0;

  video_center_crop_pad_unit uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_addr     (cfg_addr),
    .cfg_data     (cfg_data),
    .push         (push),
    .full         (full),
    .luma         (luma),
    .chroma       (chroma),
    .frame_start  (frame_start),
    .empty        (empty),
    .pop          (pop),
    .out_luma     (out_luma),
    .out_chroma   (out_chroma),
    .repeat_count (repeat_count),
    .group_last   (group_last),
    .frame_last   (frame_last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int unsigned dim_eff(input logic [REG_W-1:0] v);
    if (v == 0) return 1;
    if (32'(v) > DIM_CAP) return DIM_CAP;
    return 32'(v);
  endfunction

  // Either the source is cropped to the center or padded around it; an odd
  // difference leaves the extra pad on the far side.
  function automatic void split_axis(input int unsigned src, input int unsigned dst,
                                     output int unsigned skip, output int unsigned pre,
                                     output int unsigned post, output int unsigned keep);
    if (src > dst) begin
      skip = (src - dst) / 2;
      pre  = 0;
      post = 0;
      keep = dst;
    end else begin
      skip = 0;
      pre  = (dst - src) / 2;
      post = (dst - src) - pre;
      keep = src;
    end
  endfunction

  function automatic run_t pad_run(input int unsigned n);
    run_t r;
    r.luma      = PAD_LUMA;
    r.chroma    = PAD_CHROMA;
    r.count     = (n > CNT_MAX) ? CNT_MAX : n[CNT_W-1:0];
    r.group_end = 1'b0;
    r.frame_end = 1'b0;
    return r;
  endfunction

  function automatic void predict_crop_pad(input pixel_t px);
    int unsigned iw, ih, ow, oh, sx, lp, rp, kw, sy, tp, bp, kh;
    run_t        runs[$];
    run_t        pix;
    bit          frame_tail;
    frame_tail = 1'b0;
    if (px.frame_start) begin
      src_col  = 0;
      src_row  = 0;
      src_done = 1'b0;
    end
    if (src_done) return;
    iw = dim_eff(in_w_reg);
    ih = dim_eff(in_h_reg);
    ow = dim_eff(out_w_reg);
    oh = dim_eff(out_h_reg);
    split_axis(iw, ow, sx, lp, rp, kw);
    split_axis(ih, oh, sy, tp, bp, kh);
    if (src_col == 0 && src_row == 0 && tp > 0) runs.push_back(pad_run(tp * ow));
    if (src_row >= sy && src_row < sy + kh) begin
      if (src_col == 0 && lp > 0) runs.push_back(pad_run(lp));
      if (src_col >= sx && src_col < sx + kw) begin
        pix = {px.luma, px.chroma, 25'd1, 1'b0, 1'b0};
        runs.push_back(pix);
        if (src_col == sx + kw - 1) begin
          if (rp > 0) runs.push_back(pad_run(rp));
          if (src_row == sy + kh - 1) begin
            if (bp > 0) runs.push_back(pad_run(bp * ow));
            frame_tail = 1'b1;
          end
        end
      end
    end
    if (runs.size() > 0) begin
      runs[runs.size() - 1].group_end = 1'b1;
      runs[runs.size() - 1].frame_end = frame_tail;
    end
    foreach (runs[i]) expected_runs.push_back(runs[i]);
    src_col++;
    if (src_col >= iw) begin
      src_col = 0;
      src_row++;
      if (src_row >= ih) begin
        src_row  = 0;
        src_done = 1'b1;
      end
    end
  endfunction

  function automatic bit take_break();
    return !calm && ($urandom_range(99) < 7);
  endfunction

  always @(posedge clk) begin : drive_blk
    pixel_t nxt;
    if (rst) begin
      push <= 1'b0;
    end else if (!push || !full) begin
      if (push) predict_crop_pad({luma, chroma, frame_start});
      if (pending_pixels.size() > 0 && !take_break()) begin
        nxt = pending_pixels.pop_front();
        push        <= 1'b1;
        luma        <= nxt.luma;
        chroma      <= nxt.chroma;
        frame_start <= nxt.frame_start;
      end else begin
        push <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : watch_blk
    run_t got, want;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        got = {out_luma, out_chroma, repeat_count, group_last, frame_last};
        if (expected_runs.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display({"unexpected result: luma %0d chroma %0d count %0d",
                      " group_last %0b frame_last %0b"},
                     got.luma, got.chroma, got.count, got.group_end, got.frame_end);
        end else begin
          want = expected_runs.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10)
              $display({"mismatch: expected luma %0d chroma %0d count %0d",
                        " group_last %0b frame_last %0b, got luma %0d chroma %0d",
                        " count %0d group_last %0b frame_last %0b"},
                       want.luma, want.chroma, want.count, want.group_end, want.frame_end,
                       got.luma, got.chroma, got.count, got.group_end, got.frame_end);
          end
        end
      end
      pop <= !take_break();
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("video_center_crop_pad_unit regression: fail");
      $finish;
    end
  end

  task automatic queue_pixel(input logic fs, input logic [7:0] y, input logic [7:0] c);
    pending_pixels.push_back({y, c, fs});
    items_sent++;
  endtask

  // Waits until every transfer has gone through, then lets the pipeline run dry.
  task automatic settle_empty();
    do @(negedge clk);
    while (pending_pixels.size() != 0 || push || expected_runs.size() != 0);
    repeat (8) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_reg(input cfg_reg_t idx, input logic [REG_W-1:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_addr  <= idx;
    cfg_data  <= val;
    case (idx)
      REG_IN_WIDTH:   in_w_reg = val;
      REG_IN_HEIGHT:  in_h_reg = val;
      REG_OUT_WIDTH:  out_w_reg = val;
      REG_OUT_HEIGHT: out_h_reg = val;
      default: ;
    endcase
  endtask

  // Drops the write strobe and waits for the derived geometry to settle after the last write.
  task automatic finish_config();
    @(posedge clk);
    cfg_write <= 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [REG_W-1:0] pick_src_dim();
    int unsigned r;
    r = $urandom_range(15);
    if (r == 0) return '0;
    if (r == 1) return REG_W'($urandom_range(12, 7));
    return REG_W'($urandom_range(6, 1));
  endfunction

  function automatic logic [REG_W-1:0] pick_dst_dim();
    int unsigned r;
    r = $urandom_range(15);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r == 2) return REG_W'(DIM_CAP);
    if (r == 3) return REG_W'($urandom_range(8190, DIM_CAP + 1));
    return REG_W'($urandom_range(9, 1));
  endfunction

  initial begin : stimulus
    int unsigned frame_px, n_frames, phase, k, roll;
    logic fs;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);

    // Reset geometry: source and output match, so every pixel passes through.
    queue_pixel(1'b1, 8'h00, 8'hFF);
    queue_pixel(1'b0, 8'hFF, 8'h00);
    queue_pixel(1'b0, 8'hAA, 8'h55);
    settle_empty();

    // Zero sizes act as one and oversized ones as the maximum, so a single
    // pixel produces all five runs. The pixel after it falls past frame end.
    set_reg(REG_IN_WIDTH, '0);
    set_reg(REG_IN_HEIGHT, '0);
    set_reg(REG_OUT_WIDTH, '1);
    set_reg(REG_OUT_HEIGHT, '1);
    finish_config();
    queue_pixel(1'b1, 8'h12, 8'h34);
    queue_pixel(1'b0, 8'h56, 8'h78);
    queue_pixel(1'b1, 8'h9A, 8'hBC);
    settle_empty();

    // Odd pad differences put the extra column and row on the right and bottom.
    set_reg(REG_IN_WIDTH, 2);
    set_reg(REG_IN_HEIGHT, 1);
    set_reg(REG_OUT_WIDTH, 5);
    set_reg(REG_OUT_HEIGHT, 4);
    finish_config();
    queue_pixel(1'b1, 8'h01, 8'h02);
    queue_pixel(1'b0, 8'h03, 8'h04);
    settle_empty();

    // Odd crop differences drop the extra column and row on the right and bottom.
    set_reg(REG_IN_WIDTH, 3);
    set_reg(REG_IN_HEIGHT, 2);
    set_reg(REG_OUT_WIDTH, 2);
    set_reg(REG_OUT_HEIGHT, 1);
    finish_config();
    queue_pixel(1'b1, 8'h21, 8'h22);
    for (k = 1; k < 6; k++)
      queue_pixel(1'b0, 8'($urandom_range(255)), 8'($urandom_range(255)));
    settle_empty();

    // Shrink the source width mid-frame so the current column lies beyond it.
    set_reg(REG_IN_WIDTH, 4);
    set_reg(REG_IN_HEIGHT, 2);
    set_reg(REG_OUT_WIDTH, 4);
    set_reg(REG_OUT_HEIGHT, 2);
    finish_config();
    queue_pixel(1'b1, 8'h31, 8'h32);
    queue_pixel(1'b0, 8'h33, 8'h34);
    queue_pixel(1'b0, 8'h35, 8'h36);
    settle_empty();
    set_reg(REG_IN_WIDTH, 2);
    finish_config();
    queue_pixel(1'b0, 8'h37, 8'h38);
    queue_pixel(1'b0, 8'h39, 8'h3A);
    queue_pixel(1'b0, 8'h3B, 8'h3C);

    phase = 0;
    while (items_sent < 300) begin
      settle_empty();
      calm = (phase >= 4 && phase < 8);
      if ($urandom_range(1)) set_reg(REG_IN_WIDTH, pick_src_dim());
      if ($urandom_range(1)) set_reg(REG_IN_HEIGHT, pick_src_dim());
      if ($urandom_range(1)) set_reg(REG_OUT_WIDTH, pick_dst_dim());
      if ($urandom_range(1)) set_reg(REG_OUT_HEIGHT, pick_dst_dim());
      finish_config();
      n_frames = $urandom_range(3, 1);
      repeat (n_frames) begin
        frame_px = dim_eff(in_w_reg) * dim_eff(in_h_reg);
        for (k = 0; k < frame_px; k++) begin
          fs = (k == 0);
          roll = $urandom_range(29);
          // Now and then a frame start goes missing or turns up mid-frame,
          // or the frame is cut short.
          if (roll == 0) fs = !fs;
          if (roll == 1) break;
          queue_pixel(fs, 8'($urandom_range(255)), 8'($urandom_range(255)));
          if ($urandom_range(39) == 0) settle_empty();
        end
        if ($urandom_range(3) == 0)
          repeat ($urandom_range(2, 1))
            queue_pixel(1'b0, 8'($urandom_range(255)), 8'($urandom_range(255)));
      end
      phase++;
    end

    settle_empty();
    if (errors == 0) begin
      $display("video_center_crop_pad_unit regression: pass");
    end else begin
      $display("video_center_crop_pad_unit regression: fail");
    end
    $finish;
  end

endmodule
